/* sv/constant_database_lookup_top_assert.svh */
// Assertion macros shared by the lookup block.
`ifndef CONSTANT_DATABASE_LOOKUP_TOP_ASSERT_SVH
`define CONSTANT_DATABASE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdb assertion failed");

// Next-cycle implication, checked outside reset.
`define CDB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdb assertion failed");

`endif

/* sv/cdb_pkg.sv */
package cdb_pkg;
	localparam int IMAGE_BYTES   = 16384;
	localparam int ADDR_W        = 14;
	localparam int SIZE_W        = 15;
	localparam int MAX_KEY_BYTES = 64;
	localparam int KEY_AW        = 6;
	localparam int KLEN_W        = 7;
	localparam int SLOT_W        = 14;
	localparam int HEADER_BYTES  = 2048;
	localparam int S_TDATA_W     = 24;
	localparam int M_TDATA_W     = 48;
	localparam logic [31:0] HASH_SEED = 32'd5381;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_OPEN  = 2'd1;
	localparam logic [1:0] REQ_KEY   = 2'd2;
	localparam logic [1:0] REQ_NEXT  = 2'd3;

	localparam logic [2:0] ST_OPENED    = 3'd0;
	localparam logic [2:0] ST_NOT_OPEN  = 3'd1;
	localparam logic [2:0] ST_FORMAT    = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_BEYOND    = 3'd5;
	localparam logic [2:0] ST_KEY_LONG  = 3'd6;
endpackage

/* sv/constant_database_lookup_top.sv */
// Constant-database lookup engine. The database image is loaded one byte per item, taken only
// while the sequencer is idle, into a 16384-byte on-chip memory with a single byte-wide
// registered read port; that port sets the speed of everything else. Key bytes are also
// hashed on the fly. Every 32-bit field is fetched as four byte reads. An open walks the 256
// header descriptors in order and stops early at a malformed one. A lookup reads the
// descriptor, forms the start-slot remainder in a bit-serial divider, probes slots in turn,
// reads the record lengths for each slot whose hash matches, and compares the key byte by
// byte. Find-next resumes the same probe loop. Only one request is in work at a time; a
// finished result waits in the output register while the next item may already be taken.
module constant_database_lookup_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         image_size_we,
	input  logic [cdb_pkg::SIZE_W-1:0]   image_size_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// image_address [13:0], data_byte [21:14], zero fill above
	input  logic [cdb_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type [1:0], byte_valid [2]
	input  logic [2:0]                   s_tuser,
	// last_key_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// value_offset [14:0], value_length [29:15], record_count [43:30], zero fill above
	output logic [cdb_pkg::M_TDATA_W-1:0] m_tdata,
	// status [2:0]
	output logic [2:0]                   m_tuser
);
	import cdb_pkg::*;

	// Sequencer states. RD is a shared four-byte word fetch that returns to ret_q.
	typedef enum logic [4:0] {
		IDLE, RD, OPEN_POS, OPEN_CHK, OPEN_END, LK_START, LK_DESC, LK_CHK, DIV,
		PR_TOP, PR_SH, PR_DP, PR_KLEN, PR_VLEN, CMP_RD, CMP_CHK, FIN
	} state_t;

	state_t state_q, ret_q;

	logic [SIZE_W-1:0] image_size_q;
	logic [ADDR_W-1:0] rd_base_q;
	logic [2:0]        rd_cnt_q;
	logic [31:0]       word_q, w0_q, sh_q, klen_q;
	logic [7:0]        idx_q;
	logic [SIZE_W-1:0] dend_q, data_end_q, table_start_q, table_end_q, next_slot_q, slot_q;
	logic [SLOT_W-1:0] snum_q, total_slots_q, slots_left_q;
	logic [ADDR_W-1:0] dp_q;
	logic [SIZE_W-1:0] toff_q, vlen_q;
	logic [23:0]       dq_q;
	logic [12:0]       rem_q;
	logic [11:0]       divisor_q;
	logic [4:0]        dcnt_q;
	logic [KLEN_W-1:0] cmp_i_q, key_length_q;
	logic [31:0]       hash_q;
	logic              key_closed_q, key_ovf_q;
	logic [2:0]        lookup_status_q, res_st_q;
	logic              m_tvalid_q;
	logic [2:0]        out_st_q;
	logic [SIZE_W-1:0] out_off_q, out_len_q;
	logic [SLOT_W-1:0] out_rc_q;

	// Image memory and key buffer: one write and one registered read per cycle each.
	logic [7:0]        image_mem [IMAGE_BYTES];
	logic [7:0]        key_mem [MAX_KEY_BYTES];
	logic [7:0]        mem_q, key_q;
	logic [ADDR_W-1:0] mem_raddr;
	logic              mem_we, key_we;

	logic [1:0]        req;
	logic              bvalid, accept, blocked;
	logic [ADDR_W-1:0] in_addr;
	logic [7:0]        in_byte;
	logic [SIZE_W-1:0] limit;

	// Key bookkeeping; a closed key restarts from empty on its next byte.
	logic [KLEN_W-1:0] key_base;
	logic [31:0]       hash_base, hash_new;

	// Header descriptor checks.
	logic [SIZE_W-1:0] sz_minus_pos, dend_new;
	logic [SLOT_W-1:0] snum_new;
	logic              open_bad, open_over;

	// Lookup and probe arithmetic.
	logic [10:0]       desc_addr;
	logic [35:0]       tab_sum;
	logic [15:0]       slot_end;
	logic [SIZE_W-1:0] slot_nxt;
	logic [32:0]       dp_end;
	logic [SIZE_W-1:0] rec_t, rec_t2;
	logic [12:0]       rem_sh;

	assign req     = s_tuser[1:0];
	assign bvalid  = s_tuser[2];
	assign in_addr = s_tdata[ADDR_W-1:0];
	assign in_byte = s_tdata[ADDR_W+7:ADDR_W];

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign limit    = (image_size_q > SIZE_W'(IMAGE_BYTES)) ? SIZE_W'(IMAGE_BYTES) : image_size_q;
	assign blocked  = (lookup_status_q == ST_NOT_OPEN) || (lookup_status_q == ST_FORMAT);

	assign key_base  = key_closed_q ? '0 : key_length_q;
	assign hash_base = key_closed_q ? HASH_SEED : hash_q;
	assign hash_new  = ((hash_base << 5) + hash_base) ^ {24'd0, in_byte};

	assign mem_we = accept && (req == REQ_WRITE);
	assign key_we = accept && (req == REQ_KEY) && bvalid && (key_base < KLEN_W'(MAX_KEY_BYTES));

	assign mem_raddr = (state_q == CMP_RD)
		? dp_q + ADDR_W'(8) + ADDR_W'(cmp_i_q)
		: rd_base_q + ADDR_W'(rd_cnt_q[1:0]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			image_mem[in_addr] <= in_byte;
		end
		mem_q <= image_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_base[KEY_AW-1:0]] <= in_byte;
		end
		key_q <= key_mem[cmp_i_q[KEY_AW-1:0]];
	end

	always_comb begin
		sz_minus_pos = image_size_q - w0_q[SIZE_W-1:0];
		open_bad = (w0_q < 32'(HEADER_BYTES)) || (w0_q > 32'(image_size_q))
			|| (32'(sz_minus_pos >> 3) < word_q);
		dend_new  = (w0_q[SIZE_W-1:0] < dend_q) ? w0_q[SIZE_W-1:0] : dend_q;
		snum_new  = snum_q + word_q[SLOT_W-1:0];
		open_over = SLOT_W'((image_size_q - dend_new) >> 3) < snum_new;

		desc_addr = {hash_q[7:0], 3'b000};
		tab_sum   = 36'(w0_q) + {1'b0, word_q, 3'b000};
		slot_end  = 16'(next_slot_q) + 16'd8;
		slot_nxt  = next_slot_q + SIZE_W'(8);
		dp_end    = 33'(word_q) + 33'd8;
		rec_t     = SIZE_W'(dp_q) + SIZE_W'(8);
		rec_t2    = rec_t + klen_q[SIZE_W-1:0];
		rem_sh    = {rem_q[11:0], dq_q[23]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= IDLE;
			ret_q           <= IDLE;
			image_size_q    <= '0;
			rd_base_q       <= '0;
			rd_cnt_q        <= '0;
			word_q          <= '0;
			w0_q            <= '0;
			sh_q            <= '0;
			klen_q          <= '0;
			idx_q           <= '0;
			dend_q          <= '0;
			data_end_q      <= '0;
			table_start_q   <= '0;
			table_end_q     <= '0;
			next_slot_q     <= '0;
			slot_q          <= '0;
			snum_q          <= '0;
			total_slots_q   <= '0;
			slots_left_q    <= '0;
			dp_q            <= '0;
			toff_q          <= '0;
			vlen_q          <= '0;
			dq_q            <= '0;
			rem_q           <= '0;
			divisor_q       <= '0;
			dcnt_q          <= '0;
			cmp_i_q         <= '0;
			key_length_q    <= '0;
			hash_q          <= HASH_SEED;
			key_closed_q    <= 1'b0;
			key_ovf_q       <= 1'b0;
			lookup_status_q <= ST_NOT_OPEN;
			res_st_q        <= ST_NOT_OPEN;
			m_tvalid_q      <= 1'b0;
			out_st_q        <= '0;
			out_off_q       <= '0;
			out_len_q       <= '0;
			out_rc_q        <= '0;
		end else begin
			if (image_size_we) begin
				image_size_q <= image_size_wdata;
			end
			// The finish state reloads the output register itself.
			if (m_tvalid_q && m_tready && state_q != FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						case (req)
							REQ_OPEN: begin
								slots_left_q  <= '0;
								next_slot_q   <= '0;
								data_end_q    <= '0;
								total_slots_q <= '0;
								if (image_size_q > SIZE_W'(IMAGE_BYTES)
										|| image_size_q < SIZE_W'(HEADER_BYTES)) begin
									res_st_q <= ST_FORMAT;
									state_q  <= FIN;
								end else begin
									dend_q    <= image_size_q;
									snum_q    <= '0;
									idx_q     <= '0;
									rd_base_q <= '0;
									rd_cnt_q  <= '0;
									ret_q     <= OPEN_POS;
									state_q   <= RD;
								end
							end
							REQ_KEY: begin
								key_closed_q <= s_tlast;
								hash_q       <= bvalid ? hash_new : hash_base;
								key_length_q <= (bvalid && key_base < KLEN_W'(MAX_KEY_BYTES))
									? key_base + KLEN_W'(1) : key_base;
								key_ovf_q    <= (bvalid && key_base >= KLEN_W'(MAX_KEY_BYTES))
									? 1'b1 : (key_closed_q ? 1'b0 : key_ovf_q);
								if (s_tlast) begin
									if (blocked) begin
										res_st_q <= lookup_status_q;
										state_q  <= FIN;
									end else begin
										state_q <= LK_START;
									end
								end
							end
							REQ_NEXT: begin
								if (blocked) begin
									res_st_q <= lookup_status_q;
									state_q  <= FIN;
								end else begin
									state_q <= PR_TOP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				RD: begin
					// Bytes come back little-endian and shift in from the top.
					if (rd_cnt_q != 3'd0) begin
						word_q <= {mem_q, word_q[31:8]};
					end
					if (rd_cnt_q == 3'd4) begin
						state_q <= ret_q;
					end else begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
				end
				OPEN_POS: begin
					w0_q      <= word_q;
					rd_base_q <= ADDR_W'({idx_q, 3'b100});
					rd_cnt_q  <= '0;
					ret_q     <= OPEN_CHK;
					state_q   <= RD;
				end
				OPEN_CHK: begin
					if (w0_q != 32'd0 && (open_bad || open_over)) begin
						res_st_q <= ST_FORMAT;
						state_q  <= FIN;
					end else begin
						if (w0_q != 32'd0) begin
							dend_q <= dend_new;
							snum_q <= snum_new;
						end
						if (idx_q == 8'hFF) begin
							state_q <= OPEN_END;
						end else begin
							idx_q     <= idx_q + 8'd1;
							rd_base_q <= ADDR_W'({idx_q + 8'd1, 3'b000});
							rd_cnt_q  <= '0;
							ret_q     <= OPEN_POS;
							state_q   <= RD;
						end
					end
				end
				OPEN_END: begin
					if (17'(image_size_q - dend_q) != {snum_q, 3'b000}) begin
						res_st_q <= ST_FORMAT;
					end else begin
						data_end_q    <= dend_q;
						total_slots_q <= snum_q;
						res_st_q      <= ST_OPENED;
					end
					state_q <= FIN;
				end
				LK_START: begin
					if (key_ovf_q) begin
						slots_left_q <= '0;
						next_slot_q  <= '0;
						res_st_q     <= ST_KEY_LONG;
						state_q      <= FIN;
					end else if (16'(desc_addr) + 16'd8 > 16'(limit)) begin
						slots_left_q <= '0;
						next_slot_q  <= '0;
						res_st_q     <= ST_BEYOND;
						state_q      <= FIN;
					end else begin
						rd_base_q <= ADDR_W'(desc_addr);
						rd_cnt_q  <= '0;
						ret_q     <= LK_DESC;
						state_q   <= RD;
					end
				end
				LK_DESC: begin
					w0_q      <= word_q;
					rd_base_q <= ADDR_W'(desc_addr) + ADDR_W'(4);
					rd_cnt_q  <= '0;
					ret_q     <= LK_CHK;
					state_q   <= RD;
				end
				LK_CHK: begin
					if (w0_q == 32'd0 || word_q == 32'd0) begin
						slots_left_q <= '0;
						next_slot_q  <= '0;
						res_st_q     <= ST_NOT_FOUND;
						state_q      <= FIN;
					end else if (tab_sum > 36'(limit)) begin
						slots_left_q <= '0;
						next_slot_q  <= '0;
						res_st_q     <= ST_BEYOND;
						state_q      <= FIN;
					end else begin
						table_start_q <= w0_q[SIZE_W-1:0];
						table_end_q   <= tab_sum[SIZE_W-1:0];
						slots_left_q  <= word_q[SLOT_W-1:0];
						divisor_q     <= word_q[11:0];
						dq_q          <= hash_q[31:8];
						rem_q         <= '0;
						dcnt_q        <= '0;
						state_q       <= DIV;
					end
				end
				DIV: begin
					// Restoring division, one quotient bit per cycle; only the remainder matters.
					dq_q <= {dq_q[22:0], 1'b0};
					if (rem_sh >= 13'(divisor_q)) begin
						rem_q <= rem_sh - 13'(divisor_q);
					end else begin
						rem_q <= rem_sh;
					end
					if (dcnt_q == 5'd23) begin
						state_q <= PR_TOP;
						if (rem_sh >= 13'(divisor_q)) begin
							next_slot_q <= table_start_q
								+ SIZE_W'({rem_sh - 13'(divisor_q), 3'b000});
						end else begin
							next_slot_q <= table_start_q + SIZE_W'({rem_sh, 3'b000});
						end
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
					end
				end
				PR_TOP: begin
					if (slots_left_q == '0) begin
						next_slot_q <= '0;
						res_st_q    <= ST_NOT_FOUND;
						state_q     <= FIN;
					end else begin
						slot_q       <= next_slot_q;
						slots_left_q <= slots_left_q - SLOT_W'(1);
						next_slot_q  <= (slot_nxt == table_end_q) ? table_start_q : slot_nxt;
						if (slot_end > 16'(limit)) begin
							res_st_q <= ST_BEYOND;
							state_q  <= FIN;
						end else begin
							rd_base_q <= next_slot_q[ADDR_W-1:0];
							rd_cnt_q  <= '0;
							ret_q     <= PR_SH;
							state_q   <= RD;
						end
					end
				end
				PR_SH: begin
					sh_q      <= word_q;
					rd_base_q <= slot_q[ADDR_W-1:0] + ADDR_W'(4);
					rd_cnt_q  <= '0;
					ret_q     <= PR_DP;
					state_q   <= RD;
				end
				PR_DP: begin
					if (word_q == 32'd0) begin
						slots_left_q <= '0;
						next_slot_q  <= '0;
						res_st_q     <= ST_NOT_FOUND;
						state_q      <= FIN;
					end else if (word_q < 32'(HEADER_BYTES) || dp_end > 33'(data_end_q)) begin
						res_st_q <= ST_FORMAT;
						state_q  <= FIN;
					end else if (sh_q != hash_q) begin
						state_q <= PR_TOP;
					end else if (dp_end > 33'(limit)) begin
						res_st_q <= ST_BEYOND;
						state_q  <= FIN;
					end else begin
						dp_q      <= word_q[ADDR_W-1:0];
						rd_base_q <= word_q[ADDR_W-1:0];
						rd_cnt_q  <= '0;
						ret_q     <= PR_KLEN;
						state_q   <= RD;
					end
				end
				PR_KLEN: begin
					klen_q    <= word_q;
					rd_base_q <= dp_q + ADDR_W'(4);
					rd_cnt_q  <= '0;
					ret_q     <= PR_VLEN;
					state_q   <= RD;
				end
				PR_VLEN: begin
					if (32'(data_end_q - rec_t) < klen_q
							|| 32'(data_end_q - rec_t2) < word_q) begin
						res_st_q <= ST_FORMAT;
						state_q  <= FIN;
					end else if (32'(key_length_q) != klen_q) begin
						state_q <= PR_TOP;
					end else if (16'(rec_t2) > 16'(limit)) begin
						res_st_q <= ST_BEYOND;
						state_q  <= FIN;
					end else begin
						toff_q  <= rec_t2;
						vlen_q  <= word_q[SIZE_W-1:0];
						cmp_i_q <= '0;
						if (key_length_q == '0) begin
							res_st_q <= ST_FOUND;
							state_q  <= FIN;
						end else begin
							state_q <= CMP_RD;
						end
					end
				end
				CMP_RD: begin
					state_q <= CMP_CHK;
				end
				CMP_CHK: begin
					if (mem_q != key_q) begin
						state_q <= PR_TOP;
					end else if (cmp_i_q + KLEN_W'(1) == key_length_q) begin
						res_st_q <= ST_FOUND;
						state_q  <= FIN;
					end else begin
						cmp_i_q <= cmp_i_q + KLEN_W'(1);
						state_q <= CMP_RD;
					end
				end
				FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q      <= 1'b1;
						out_st_q        <= res_st_q;
						out_off_q       <= (res_st_q == ST_FOUND) ? toff_q : '0;
						out_len_q       <= (res_st_q == ST_FOUND) ? vlen_q : '0;
						out_rc_q        <= {1'b0, total_slots_q[SLOT_W-1:1]};
						lookup_status_q <= res_st_q;
						state_q         <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {4'd0, out_rc_q, out_len_q, out_off_q};

`include "constant_database_lookup_top_assert.svh"

	// A found value lies wholly inside the image memory.
	`CDB_ASSERT_NOW(a_found_inside, m_tvalid_q && out_st_q == ST_FOUND, 16'(out_off_q) + 16'(out_len_q) <= 16'(IMAGE_BYTES))
	// Every other result carries a zero offset and length.
	`CDB_ASSERT_NOW(a_miss_zero, m_tvalid_q && out_st_q != ST_FOUND, out_off_q == '0 && out_len_q == '0)
	// The stored key never grows past the key buffer.
	`CDB_ASSERT_NOW(a_key_fits, 1'b1, key_length_q <= KLEN_W'(MAX_KEY_BYTES))
	// The divider only runs on a nonzero slot count.
	`CDB_ASSERT_NOW(a_div_nonzero, state_q == DIV, divisor_q != '0)
	// A result leaves the finish state only into the output register.
	`CDB_ASSERT_NEXT(a_fin_loads, state_q == FIN && (!m_tvalid_q || m_tready), m_tvalid_q && state_q == IDLE)

endmodule
